// ===== rtl/crcwp_pkg.sv =====
`timescale 1ns / 1ps

package crcwp_pkg;

  localparam int unsigned FrameBytes = 6;
  localparam int unsigned PosWidth   = $clog2(FrameBytes);

  localparam logic [7:0] CrcPolyReset  = 8'h31;
  localparam logic [7:0] CrcStartReset = 8'hFF;

  typedef enum logic [0:0] {
    CFG_CRC_POLY  = 1'b0,
    CFG_CRC_START = 1'b1
  } crcwp_cfg_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FIRST_BAD  = 2'd1,
    ST_SECOND_BAD = 2'd2
  } crcwp_status_e;

  typedef enum logic [PosWidth-1:0] {
    POS_W1_HI  = 3'd0,
    POS_W1_LO  = 3'd1,
    POS_W1_CRC = 3'd2,
    POS_W2_HI  = 3'd3,
    POS_W2_LO  = 3'd4,
    POS_W2_CRC = 3'd5
  } crcwp_pos_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } crcwp_req_t;

  typedef struct packed {
    logic [15:0]   first_word;
    logic [15:0]   second_word;
    crcwp_status_e frame_status;
  } crcwp_rsp_t;

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_absorb(logic [7:0] rem, logic [7:0] data,
                                             logic [7:0] poly);
    logic [7:0] r;
    r = rem ^ data;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ poly;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/crc_checked_word_pair_receiver.sv =====
`timescale 1ns / 1ps

// Receives a six-byte sensor frame one byte per request: first word (MSB
// first), its CRC-8, second word, its CRC-8. After the sixth byte one result
// carries both words and a status (ok, first word bad, second word bad; the
// first word wins when both fail); words read zero unless the status is ok.
// frame_start forces the byte to frame position 0 and drops any partial
// frame. CRC is MSB first with the polynomial and start value from the two
// configuration registers (reset 0x31 and 0xFF), reloaded per word. One byte
// is taken every clock unless the last byte of a frame meets a stalled result;
// a byte passes an input register and the combinational CRC-8 update into a
// registered result. Bytes that produce no result keep flowing during a stall.
module crc_checked_word_pair_receiver (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  crcwp_pkg::crcwp_cfg_e    cfg_idx_i,
  input  logic [7:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  crcwp_pkg::crcwp_req_t    in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output crcwp_pkg::crcwp_rsp_t    out_rsp_o
);

  logic [7:0] poly_q, start_q;

  logic                  in_valid_q;
  crcwp_pkg::crcwp_req_t in_req_q;

  logic [crcwp_pkg::PosWidth-1:0] pos_q, pos_d;
  logic [7:0]  rem_q, rem_d;
  logic [15:0] word1_q, word1_d;
  logic [15:0] word2_q, word2_d;
  logic        fail1_q, fail1_d;

  logic                  out_valid_q, out_valid_d;
  crcwp_pkg::crcwp_rsp_t out_rsp_q, out_rsp_d;

  crcwp_pkg::crcwp_pos_e pos;
  logic                  out_busy, proc_go, in_load;
  logic [7:0]            crc_in, crc_out;
  crcwp_pkg::crcwp_status_e status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= crcwp_pkg::CrcPolyReset;
      start_q <= crcwp_pkg::CrcStartReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crcwp_pkg::CFG_CRC_POLY:  poly_q  <= cfg_wdata_i;
        crcwp_pkg::CFG_CRC_START: start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_req_q.frame_start ||
        pos_q >= crcwp_pkg::PosWidth'(crcwp_pkg::FrameBytes)) begin
      pos = crcwp_pkg::POS_W1_HI;
    end else begin
      pos = crcwp_pkg::crcwp_pos_e'(pos_q);
    end
  end

  assign out_busy   = out_valid_q && out_stall_i;
  assign proc_go    = in_valid_q && !(out_busy && pos == crcwp_pkg::POS_W2_CRC);
  assign in_stall_o = in_valid_q && !proc_go;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (proc_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_req_q <= in_req_i;
    end
  end

  assign crc_in  = (pos == crcwp_pkg::POS_W1_HI || pos == crcwp_pkg::POS_W2_HI) ?
                   start_q : rem_q;
  assign crc_out = crcwp_pkg::crc8_absorb(crc_in, in_req_q.rx_byte, poly_q);

  always_comb begin
    if (fail1_q) begin
      status = crcwp_pkg::ST_FIRST_BAD;
    end else if (rem_q != in_req_q.rx_byte) begin
      status = crcwp_pkg::ST_SECOND_BAD;
    end else begin
      status = crcwp_pkg::ST_OK;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    rem_d       = rem_q;
    word1_d     = word1_q;
    word2_d     = word2_q;
    fail1_d     = fail1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    if (proc_go) begin
      pos_d = (pos == crcwp_pkg::POS_W2_CRC) ? '0 : crcwp_pkg::PosWidth'(pos + 1'b1);
      case (pos)
        crcwp_pkg::POS_W1_HI: begin
          rem_d   = crc_out;
          word1_d = {in_req_q.rx_byte, 8'h00};
        end
        crcwp_pkg::POS_W1_LO: begin
          rem_d   = crc_out;
          word1_d = {word1_q[15:8], in_req_q.rx_byte};
        end
        crcwp_pkg::POS_W1_CRC: begin
          fail1_d = rem_q != in_req_q.rx_byte;
        end
        crcwp_pkg::POS_W2_HI: begin
          rem_d   = crc_out;
          word2_d = {in_req_q.rx_byte, 8'h00};
        end
        crcwp_pkg::POS_W2_LO: begin
          rem_d   = crc_out;
          word2_d = {word2_q[15:8], in_req_q.rx_byte};
        end
        default: begin
          out_valid_d            = 1'b1;
          out_rsp_d.frame_status = status;
          out_rsp_d.first_word   = (status == crcwp_pkg::ST_OK) ? word1_q : 16'h0000;
          out_rsp_d.second_word  = (status == crcwp_pkg::ST_OK) ? word2_q : 16'h0000;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rem_q       <= '0;
      word1_q     <= '0;
      word2_q     <= '0;
      fail1_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      word1_q     <= word1_d;
      word2_q     <= word2_d;
      fail1_q     <= fail1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < crcwp_pkg::PosWidth'(crcwp_pkg::FrameBytes))
    else $error("byte position out of frame");

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.frame_status != crcwp_pkg::ST_OK |->
      out_rsp_q.first_word == 16'h0000 && out_rsp_q.second_word == 16'h0000)
    else $error("words not cleared on failed frame");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_go) && $past(pos) == crcwp_pkg::POS_W2_CRC)
    else $error("result not caused by last frame byte");

endmodule

// ===== dv/crcwp_checker.sv =====
`timescale 1ns / 1ps

module crcwp_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  crcwp_pkg::crcwp_cfg_e cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  crcwp_pkg::crcwp_req_t in_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  crcwp_pkg::crcwp_rsp_t out_rsp_i,
  output int                    errors_o,
  output int                    pending_o
);

  logic [7:0]                     poly_q;
  logic [7:0]                     seed_q;
  logic [7:0]                     rem_q;
  logic [15:0]                    word1_q;
  logic [15:0]                    word2_q;
  logic                           word1_bad_q;
  logic [crcwp_pkg::PosWidth-1:0] pos_q;
  crcwp_pkg::crcwp_rsp_t          frames_q[$];
  int                             errors = 0;
  int                             waiting = 0;

  assign errors_o  = errors;
  assign pending_o = waiting;

  function automatic logic [7:0] crc_update(logic [7:0] rem, logic [7:0] data,
                                            logic [7:0] poly);
    logic [7:0] r;
    logic       carry;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      carry = r[7] ^ data[i];
      r = r << 1;
      if (carry) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [35:0] got, logic [35:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [crcwp_pkg::PosWidth-1:0] pos;
    crcwp_pkg::crcwp_rsp_t          want;
    crcwp_pkg::crcwp_rsp_t          frame;
    if (!rst_ni) begin
      poly_q      = crcwp_pkg::CrcPolyReset;
      seed_q      = crcwp_pkg::CrcStartReset;
      rem_q       = '0;
      word1_q     = '0;
      word2_q     = '0;
      word1_bad_q = 1'b0;
      pos_q       = crcwp_pkg::POS_W1_HI;
      frames_q.delete();
      waiting     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          crcwp_pkg::CFG_CRC_POLY: begin
            poly_q = cfg_wdata_i;
          end
          crcwp_pkg::CFG_CRC_START: begin
            seed_q = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (frames_q.size() == 0) begin
          report_mismatch("result with none expected", out_rsp_i, '0);
        end else begin
          want = frames_q.pop_front();
          if (out_rsp_i.first_word !== want.first_word) begin
            report_mismatch("first_word", out_rsp_i.first_word, want.first_word);
          end
          if (out_rsp_i.second_word !== want.second_word) begin
            report_mismatch("second_word", out_rsp_i.second_word, want.second_word);
          end
          if (out_rsp_i.frame_status !== want.frame_status) begin
            report_mismatch("frame_status", out_rsp_i.frame_status, want.frame_status);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        pos = in_req_i.frame_start ? crcwp_pkg::POS_W1_HI : pos_q;
        if (pos > crcwp_pkg::POS_W2_CRC) begin
          pos = crcwp_pkg::POS_W1_HI;
        end
        case (pos)
          crcwp_pkg::POS_W1_HI: begin
            rem_q   = crc_update(seed_q, in_req_i.rx_byte, poly_q);
            word1_q = {in_req_i.rx_byte, 8'h00};
          end
          crcwp_pkg::POS_W1_LO: begin
            rem_q        = crc_update(rem_q, in_req_i.rx_byte, poly_q);
            word1_q[7:0] = in_req_i.rx_byte;
          end
          crcwp_pkg::POS_W1_CRC: begin
            word1_bad_q = (rem_q != in_req_i.rx_byte);
          end
          crcwp_pkg::POS_W2_HI: begin
            rem_q   = crc_update(seed_q, in_req_i.rx_byte, poly_q);
            word2_q = {in_req_i.rx_byte, 8'h00};
          end
          crcwp_pkg::POS_W2_LO: begin
            rem_q        = crc_update(rem_q, in_req_i.rx_byte, poly_q);
            word2_q[7:0] = in_req_i.rx_byte;
          end
          default: begin
            if (word1_bad_q) begin
              frame.frame_status = crcwp_pkg::ST_FIRST_BAD;
            end else if (rem_q != in_req_i.rx_byte) begin
              frame.frame_status = crcwp_pkg::ST_SECOND_BAD;
            end else begin
              frame.frame_status = crcwp_pkg::ST_OK;
            end
            frame.first_word  = (frame.frame_status == crcwp_pkg::ST_OK) ? word1_q : 16'h0000;
            frame.second_word = (frame.frame_status == crcwp_pkg::ST_OK) ? word2_q : 16'h0000;
            frames_q.push_back(frame);
          end
        endcase
        pos_q = (pos == crcwp_pkg::POS_W2_CRC) ? crcwp_pkg::POS_W1_HI : pos + 1'b1;
      end
      waiting = frames_q.size();
    end
  end

endmodule

// ===== dv/tb_crc_checked_word_pair_receiver.sv =====
`timescale 1ns / 1ps

module tb_crc_checked_word_pair_receiver;

  localparam int MaxCycles = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  crcwp_pkg::crcwp_cfg_e cfg_idx;
  logic [7:0]            cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  crcwp_pkg::crcwp_req_t in_req;
  logic                  out_valid;
  logic                  out_stall;
  crcwp_pkg::crcwp_rsp_t out_rsp;

  int         errors;
  int         pending;
  int         cycles = 0;
  int         sent;
  logic [7:0] cur_poly;
  logic [7:0] cur_seed;
  logic       in_sync;
  logic       idle_en;
  logic       hold_off_req;
  logic       hold_off_done;

  crc_checked_word_pair_receiver dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  crcwp_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_stall     = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_stall <= idle_en && ($urandom_range(99) < 14);
    end
  end

  function automatic logic [7:0] word_crc(logic [15:0] w);
    logic [7:0] r;
    r = cur_seed;
    for (int i = 15; i >= 0; i--) begin
      r = (r[7] ^ w[i]) ? ((r << 1) ^ cur_poly) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s);
    while (idle_en && ($urandom_range(99) < 14)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_req.rx_byte     <= b;
    in_req.frame_start <= s;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    sent++;
  endtask

  task automatic send_frame(input logic [15:0] w1, input logic [15:0] w2,
                            input logic [7:0] e1, input logic [7:0] e2, input logic mark);
    push_byte(w1[15:8], mark);
    push_byte(w1[7:0], 1'b0);
    push_byte(word_crc(w1) ^ e1, 1'b0);
    push_byte(w2[15:8], 1'b0);
    push_byte(w2[7:0], 1'b0);
    push_byte(word_crc(w2) ^ e2, 1'b0);
    in_sync = 1'b1;
  endtask

  task automatic random_traffic();
    int         kind;
    int         n;
    logic [7:0] e1;
    logic [7:0] e2;
    kind = $urandom_range(99);
    if (kind < 80) begin
      e1   = 8'h00;
      e2   = 8'h00;
      kind = $urandom_range(99);
      if (kind < 12) begin
        e1 = 8'($urandom_range(1, 255));
      end else if (kind < 24) begin
        e2 = 8'($urandom_range(1, 255));
      end else if (kind < 30) begin
        e1 = 8'($urandom_range(1, 255));
        e2 = 8'($urandom_range(1, 255));
      end
      send_frame(pick_word(), pick_word(), e1, e2, !in_sync || ($urandom_range(1) == 1));
    end else if (kind < 90) begin
      // drop a partial frame
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        push_byte(8'($urandom), (i == 0) && (!in_sync || ($urandom_range(1) == 1)));
      end
      in_sync = 1'b0;
    end else begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        push_byte(8'($urandom), $urandom_range(4) == 0);
      end
      in_sync = 1'b0;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic [7:0] poly, input logic [7:0] seed, input int n_bytes,
                           input logic quiet, input logic squeeze);
    int target;
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= crcwp_pkg::CFG_CRC_POLY;
    cfg_wdata <= poly;
    @(negedge clk);
    cfg_idx   <= crcwp_pkg::CFG_CRC_START;
    cfg_wdata <= seed;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_poly = poly;
    cur_seed = seed;
    @(posedge clk);
    idle_en      = !quiet;
    hold_off_req = hold_off_req || squeeze;
    @(negedge clk);
    target = sent + n_bytes;
    while (sent < target) begin
      random_traffic();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = crcwp_pkg::CFG_CRC_POLY;
    cfg_wdata    = 8'h00;
    in_valid     = 1'b0;
    in_req       = '0;
    idle_en      = 1'b1;
    hold_off_req = 1'b0;
    cur_poly     = crcwp_pkg::CrcPolyReset;
    cur_seed     = crcwp_pkg::CrcStartReset;
    in_sync      = 1'b1;
    sent         = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b1);
    // abandon a frame after two bytes
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 8'h01, 8'h80, 1'b1);
    send_frame(16'h8001, 16'h7FFE, 8'h00, 8'hFF, 1'b0);
    send_frame(16'hBEEF, 16'h1234, 8'hFF, 8'h00, 1'b0);

    run_phase(8'h00, 8'h00, 300, 1'b0, 1'b0);
    run_phase(8'hFF, 8'hFF, 300, 1'b1, 1'b0);
    run_phase(8'h07, 8'h00, 300, 1'b0, 1'b1);
    run_phase(8'($urandom), 8'($urandom), 300, 1'b0, 1'b0);
    run_phase(8'h80, 8'h01, 300, 1'b0, 1'b0);
    run_phase(crcwp_pkg::CrcPolyReset, crcwp_pkg::CrcStartReset, 300, 1'b0, 1'b0);

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
